### rtl/bpf_pkg.sv
// ----------------------------------------------------------------------------
// bpf_pkg: shared types and constants of the bin packing allocator
// Request and policy codes, FSM states, and the control structs that travel
// between the controller and the row of bin cells.
// ----------------------------------------------------------------------------
package bpf_pkg;

  // Default configuration
  localparam int MaxBinsDef  = 64;
  localparam int SizeBitsDef = 16;

  // Request codes
  localparam logic ReqPlace = 1'b0;
  localparam logic ReqClear = 1'b1;

  // Fit policy codes
  localparam logic PolFirst = 1'b0;
  localparam logic PolBest  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  // Control part of the search packet moving down the cell row
  typedef struct packed {
    logic valid;
    logic found;
  } srch_flags_t;

  // Write command broadcast to all cells
  typedef struct packed {
    logic wr_fill;
    logic wr_new;
  } upd_cmd_t;

endpackage

### rtl/bin_packing_fit_allocator.sv
// ----------------------------------------------------------------------------
// bin_packing_fit_allocator: online first fit / best fit bin packing
// Controller plus a row of MAX_BINS bin cells that a search packet walks.
// ----------------------------------------------------------------------------
// Each bin lives in a cell of its own. A place request launches a search
// packet into cell 0; the packet moves one cell per clock down the whole row,
// and every open bin it passes may claim it (first fit keeps the first
// claimer, best fit the smallest positive leftover, lowest index on ties).
// When the packet leaves the last cell the controller writes the chosen bin,
// or opens a new bin at index bins_in_use, or flags table_full and drops the
// item. A place request therefore occupies the block while its packet walks
// the row and its result is written, a clear request only while its result is
// written. One request is in work at a time; the result sits in an output
// register, so the next request is taken while an earlier result is still
// stalled. fit_policy may only be written while the block is idle. Bin
// contents have no reset; only bins below the open count are ever looked at.
module bin_packing_fit_allocator #(
  parameter  int MAX_BINS  = bpf_pkg::MaxBinsDef,
  parameter  int SIZE_BITS = bpf_pkg::SizeBitsDef,
  localparam int IdxW      = $clog2(MAX_BINS),
  localparam int CntW      = $clog2(MAX_BINS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [SIZE_BITS-1:0] item_size_i,
  input  logic [SIZE_BITS-1:0] new_bin_capacity_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IdxW-1:0]      bin_index_o,
  output logic                 opened_new_o,
  output logic                 table_full_o,
  output logic [CntW-1:0]      bins_in_use_o
);

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BINS);

  bpf_pkg::state_e state_q, state_d;

  logic                 fit_policy_q, fit_policy_d;
  logic [CntW-1:0]      count_q, count_d;

  // held request
  logic                 clear_q, clear_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [SIZE_BITS-1:0] cap_q, cap_d;

  // search outcome
  logic                 hit_q, hit_d;
  logic [IdxW-1:0]      where_q, where_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [IdxW-1:0]      out_idx_q, out_idx_d;
  logic                 out_open_q, out_open_d;
  logic                 out_full_q, out_full_d;
  logic [CntW-1:0]      out_cnt_q, out_cnt_d;

  logic                 accept;
  logic                 out_free;

  // cell row links; entry 0 is driven here, entry i+1 by cell i
  bpf_pkg::srch_flags_t chain_flags [0:MAX_BINS];
  logic [SIZE_BITS-1:0] chain_size  [0:MAX_BINS];
  logic [SIZE_BITS-1:0] chain_left  [0:MAX_BINS];
  logic [IdxW-1:0]      chain_idx   [0:MAX_BINS];

  bpf_pkg::upd_cmd_t    upd;
  logic [IdxW-1:0]      upd_idx;

  // Take a request only while idle
  assign in_stall_o = (state_q != bpf_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Launch a fresh packet into the first cell on every accepted place request
  always_comb begin
    chain_flags[0].valid = accept && (req_type_i == bpf_pkg::ReqPlace);
    chain_flags[0].found = 1'b0;
    chain_size[0]        = item_size_i;
    chain_left[0]        = '0;
    chain_idx[0]         = '0;
  end

  for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
    bpf_cell #(
      .MAX_BINS  (MAX_BINS),
      .SIZE_BITS (SIZE_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .policy_best_i (fit_policy_q == bpf_pkg::PolBest),
      .open_count_i  (count_q),
      .flags_i       (chain_flags[g]),
      .size_i        (chain_size[g]),
      .best_left_i   (chain_left[g]),
      .best_idx_i    (chain_idx[g]),
      .flags_o       (chain_flags[g+1]),
      .size_o        (chain_size[g+1]),
      .best_left_o   (chain_left[g+1]),
      .best_idx_o    (chain_idx[g+1]),
      .upd_i         (upd),
      .upd_idx_i     (upd_idx),
      .upd_size_i    (size_q),
      .upd_cap_i     (cap_q)
    );
  end

  // Controller: next state, bin update and result
  always_comb begin
    state_d      = state_q;
    fit_policy_d = cfg_we_i ? cfg_wdata_i : fit_policy_q;
    count_d      = count_q;
    clear_d      = clear_q;
    size_d       = size_q;
    cap_d        = cap_q;
    hit_d        = hit_q;
    where_d      = where_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_idx_d    = out_idx_q;
    out_open_d   = out_open_q;
    out_full_d   = out_full_q;
    out_cnt_d    = out_cnt_q;
    upd          = '0;
    upd_idx      = where_q;

    unique case (state_q)
      bpf_pkg::ST_IDLE: begin
        if (accept) begin
          clear_d = req_type_i == bpf_pkg::ReqClear;
          size_d  = item_size_i;
          cap_d   = new_bin_capacity_i;
          hit_d   = 1'b0;
          state_d = (req_type_i == bpf_pkg::ReqClear) ? bpf_pkg::ST_DONE
                                                      : bpf_pkg::ST_SEARCH;
        end
      end
      bpf_pkg::ST_SEARCH: begin
        // packet leaves the last cell: capture the winner
        if (chain_flags[MAX_BINS].valid) begin
          hit_d   = chain_flags[MAX_BINS].found;
          where_d = chain_idx[MAX_BINS];
          state_d = bpf_pkg::ST_DONE;
        end
      end
      bpf_pkg::ST_DONE: begin
        // hold until the result register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          out_open_d  = 1'b0;
          out_full_d  = 1'b0;
          priority if (clear_q) begin
            count_d = '0;
          end else if (hit_q) begin
            upd.wr_fill = 1'b1;
            out_idx_d   = where_q;
          end else if (count_q < CntMax) begin
            upd.wr_new = 1'b1;
            upd_idx    = count_q[IdxW-1:0];
            out_idx_d  = count_q[IdxW-1:0];
            out_open_d = 1'b1;
            count_d    = count_q + CntW'(1);
          end else begin
            out_full_d = 1'b1;
          end
          out_cnt_d = count_d;
          state_d   = bpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpf_pkg::ST_IDLE;
      fit_policy_q <= bpf_pkg::PolFirst;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fit_policy_q <= fit_policy_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clear_q    <= clear_d;
    size_q     <= size_d;
    cap_q      <= cap_d;
    hit_q      <= hit_d;
    where_q    <= where_d;
    out_idx_q  <= out_idx_d;
    out_open_q <= out_open_d;
    out_full_q <= out_full_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign bin_index_o   = out_idx_q;
  assign opened_new_o  = out_open_q;
  assign table_full_o  = out_full_q;
  assign bins_in_use_o = out_cnt_q;

`ifndef SYNTH
  // a packet only reaches the end of the row while a search is pending
  a_packet_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_flags[MAX_BINS].valid |-> state_q == bpf_pkg::ST_SEARCH)
    else $error("search packet left the row outside of a search");

  // a new bin is always the last open one
  a_open_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && opened_new_o) |-> CntW'(bin_index_o) == bins_in_use_o - CntW'(1))
    else $error("opened bin index does not match bin count");

  // a dropped item means the table was full
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (bins_in_use_o == CntMax && !opened_new_o))
    else $error("table_full flagged with free bins");

  // the open count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("open bin count out of range");
`endif

endmodule

### rtl/bpf_cell.sv
// ----------------------------------------------------------------------------
// bpf_cell: one bin of the allocator
// Holds capacity and fill of one bin, checks the passing search packet
// against it and hands the packet on to the next cell through its registers.
// ----------------------------------------------------------------------------
module bpf_cell #(
  parameter  int MAX_BINS  = bpf_pkg::MaxBinsDef,
  parameter  int SIZE_BITS = bpf_pkg::SizeBitsDef,
  parameter  int CELL_IDX  = 0,
  localparam int IdxW      = $clog2(MAX_BINS),
  localparam int CntW      = $clog2(MAX_BINS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  policy_best_i,
  input  logic [CntW-1:0]       open_count_i,
  // search packet in
  input  bpf_pkg::srch_flags_t  flags_i,
  input  logic [SIZE_BITS-1:0]  size_i,
  input  logic [SIZE_BITS-1:0]  best_left_i,
  input  logic [IdxW-1:0]       best_idx_i,
  // search packet out
  output bpf_pkg::srch_flags_t  flags_o,
  output logic [SIZE_BITS-1:0]  size_o,
  output logic [SIZE_BITS-1:0]  best_left_o,
  output logic [IdxW-1:0]       best_idx_o,
  // bin update
  input  bpf_pkg::upd_cmd_t     upd_i,
  input  logic [IdxW-1:0]       upd_idx_i,
  input  logic [SIZE_BITS-1:0]  upd_size_i,
  input  logic [SIZE_BITS-1:0]  upd_cap_i
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);
  localparam logic [CntW-1:0] MyCnt = CntW'(CELL_IDX);

  logic [SIZE_BITS-1:0] cap_q, cap_d;
  logic [SIZE_BITS-1:0] fill_q, fill_d;
  logic                 bin_open;
  logic [SIZE_BITS:0]   need;
  logic                 fits;
  logic [SIZE_BITS-1:0] left;
  logic                 take;
  logic                 sel;

  bpf_pkg::srch_flags_t flags_q, flags_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [SIZE_BITS-1:0] best_left_q, best_left_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;

  // Fit check; leftover is only used when the sum stays below capacity
  always_comb begin
    bin_open = MyCnt < open_count_i;
    need     = {1'b0, fill_q} + {1'b0, size_i};
    fits     = flags_i.valid && bin_open && (need < {1'b0, cap_q});
    left     = cap_q - need[SIZE_BITS-1:0];
    take     = fits && (!flags_i.found || (policy_best_i && (left < best_left_i)));

    flags_d.valid = flags_i.valid;
    flags_d.found = flags_i.found || fits;
    size_d        = size_i;
    best_left_d   = take ? left  : best_left_i;
    best_idx_d    = take ? MyIdx : best_idx_i;
  end

  // Bin contents
  always_comb begin
    sel    = upd_idx_i == MyIdx;
    cap_d  = cap_q;
    fill_d = fill_q;
    if (sel && upd_i.wr_new) begin
      cap_d  = upd_cap_i;
      fill_d = upd_size_i;
    end else if (sel && upd_i.wr_fill) begin
      fill_d = fill_q + upd_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q       <= cap_d;
    fill_q      <= fill_d;
    size_q      <= size_d;
    best_left_q <= best_left_d;
    best_idx_q  <= best_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign flags_o     = flags_q;
  assign size_o      = size_q;
  assign best_left_o = best_left_q;
  assign best_idx_o  = best_idx_q;

endmodule
